/* sv/tlw_pkg.sv */
package tlw_pkg;

	localparam int NUM_REGS  = 6;
	localparam int REG_W     = 12;
	localparam int REG_IDX_W = 3;
	localparam int STATE_W   = 4;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

	localparam reg_idx_t REG_GO       = 3'd0;
	localparam reg_idx_t REG_YELLOW   = 3'd1;
	localparam reg_idx_t REG_PRESS    = 3'd2;
	localparam reg_idx_t REG_WALK     = 3'd3;
	localparam reg_idx_t REG_FLASH    = 3'd4;
	localparam reg_idx_t REG_WALK_END = 3'd5;

	localparam logic [REG_W-1:0] GO_RESET       = 12'd300;
	localparam logic [REG_W-1:0] YELLOW_RESET   = 12'd100;
	localparam logic [REG_W-1:0] PRESS_RESET    = 12'd200;
	localparam logic [REG_W-1:0] WALK_RESET     = 12'd200;
	localparam logic [REG_W-1:0] FLASH_RESET    = 12'd50;
	localparam logic [REG_W-1:0] WALK_END_RESET = 12'd100;

	localparam logic [1:0] WALK_DARK = 2'd0;
	localparam logic [1:0] WALK_DONT = 2'd1;
	localparam logic [1:0] WALK_ON   = 2'd2;

	typedef enum logic [15:0] {
		ST_NORTH_GO     = 16'h0001,
		ST_NORTH_WAIT   = 16'h0002,
		ST_WEST_GO      = 16'h0004,
		ST_WEST_WAIT    = 16'h0008,
		ST_N_PRESS      = 16'h0010,
		ST_N_RELEASE    = 16'h0020,
		ST_W_PRESS      = 16'h0040,
		ST_W_RELEASE    = 16'h0080,
		ST_WALK         = 16'h0100,
		ST_FLASH_1      = 16'h0200,
		ST_FLASH_2      = 16'h0400,
		ST_FLASH_3      = 16'h0800,
		ST_FLASH_4      = 16'h1000,
		ST_FLASH_5      = 16'h2000,
		ST_FLASH_6      = 16'h4000,
		ST_WALK_END     = 16'h8000
	} state_t;

	typedef struct packed {
		logic [5:0]         vehicle_lights;
		logic [1:0]         walk_lights;
		logic [STATE_W-1:0] state_number;
	} lamps_t;

	localparam logic [5:0] VEH_LAMP [16] = '{
		6'h21, 6'h11, 6'h0A, 6'h0C, 6'h21, 6'h11, 6'h0A, 6'h0C,
		6'h09, 6'h09, 6'h09, 6'h09, 6'h09, 6'h09, 6'h09, 6'h09
	};

	localparam logic [1:0] WALK_LAMP [16] = '{
		WALK_DONT, WALK_DONT, WALK_DONT, WALK_DONT,
		WALK_DONT, WALK_DONT, WALK_DONT, WALK_DONT,
		WALK_ON,   WALK_DONT, WALK_DARK, WALK_DONT,
		WALK_DARK, WALK_DONT, WALK_DARK, WALK_DONT
	};

	localparam reg_idx_t DWELL_REG [16] = '{
		REG_GO, REG_YELLOW, REG_GO, REG_YELLOW,
		REG_PRESS, REG_YELLOW, REG_PRESS, REG_YELLOW,
		REG_WALK, REG_FLASH, REG_FLASH, REG_FLASH,
		REG_FLASH, REG_FLASH, REG_FLASH, REG_WALK_END
	};

	function automatic logic [STATE_W-1:0] state_num(input state_t s);
		logic [STATE_W-1:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			if (s[i]) begin
				n = STATE_W'(i);
			end
		end
		return n;
	endfunction

	// sel: bit2 walk request, bit1 north car, bit0 west car
	function automatic state_t next_state(input state_t s, input logic [2:0] sel);
		state_t n;
		case (s)
			ST_NORTH_GO:   n = sel[2] ? ST_N_PRESS : (sel[1] ? ST_NORTH_WAIT : ST_NORTH_GO);
			ST_NORTH_WAIT: n = ST_WEST_GO;
			ST_WEST_GO:    n = sel[2] ? ST_W_PRESS : (sel[0] ? ST_WEST_WAIT : ST_WEST_GO);
			ST_WEST_WAIT:  n = ST_NORTH_GO;
			ST_N_PRESS:    n = sel[2] ? ST_N_RELEASE : ST_NORTH_GO;
			ST_N_RELEASE:  n = ST_WALK;
			ST_W_PRESS:    n = sel[2] ? ST_W_RELEASE : ST_WEST_GO;
			ST_W_RELEASE:  n = ST_WALK;
			ST_WALK:       n = ST_FLASH_1;
			ST_FLASH_1:    n = ST_FLASH_2;
			ST_FLASH_2:    n = ST_FLASH_3;
			ST_FLASH_3:    n = ST_FLASH_4;
			ST_FLASH_4:    n = ST_FLASH_5;
			ST_FLASH_5:    n = ST_FLASH_6;
			ST_FLASH_6:    n = ST_WALK_END;
			ST_WALK_END:   n = (sel[1:0] == 2'b10) ? ST_WEST_GO : ST_NORTH_GO;
			default:       n = ST_NORTH_GO;
		endcase
		return n;
	endfunction

endpackage

/* sv/tlw_cfg.sv */
module tlw_cfg
	import tlw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  reg_idx_t         cfg_idx,
	input  logic [REG_W-1:0] cfg_data,
	output cfg_regs_t        regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_GO]       <= GO_RESET;
			regs_q[REG_YELLOW]   <= YELLOW_RESET;
			regs_q[REG_PRESS]    <= PRESS_RESET;
			regs_q[REG_WALK]     <= WALK_RESET;
			regs_q[REG_FLASH]    <= FLASH_RESET;
			regs_q[REG_WALK_END] <= WALK_END_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GO:       regs_q[REG_GO]       <= cfg_data;
				REG_YELLOW:   regs_q[REG_YELLOW]   <= cfg_data;
				REG_PRESS:    regs_q[REG_PRESS]    <= cfg_data;
				REG_WALK:     regs_q[REG_WALK]     <= cfg_data;
				REG_FLASH:    regs_q[REG_FLASH]    <= cfg_data;
				REG_WALK_END: regs_q[REG_WALK_END] <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

/* sv/tlw_step.sv */
module tlw_step
	import tlw_pkg::*;
(
	input  state_t           state,
	input  logic [REG_W-1:0] dwell,
	input  logic [2:0]       sel,
	input  cfg_regs_t        regs,
	output lamps_t           lamps,
	output state_t           state_nxt,
	output logic [REG_W-1:0] dwell_nxt
);

	logic [STATE_W-1:0] num;
	logic [REG_W-1:0]   limit;
	logic [REG_W:0]     elapsed;
	logic               done;

	always_comb begin
		num     = state_num(state);
		limit   = regs[DWELL_REG[num]];
		elapsed = {1'b0, dwell} + (REG_W+1)'(1);
		// a zero limit also ends the dwell on the first tick
		done    = elapsed >= {1'b0, limit};

		lamps.vehicle_lights = VEH_LAMP[num];
		lamps.walk_lights    = WALK_LAMP[num];
		lamps.state_number   = num;

		state_nxt = done ? next_state(state, sel) : state;
		dwell_nxt = done ? '0 : elapsed[REG_W-1:0];
	end

endmodule

/* sv/traffic_light_with_walk_fsm.sv */
// Each accepted input goes into the input register, then into the result register; the result
// register is loaded only when it is empty or its current result is being accepted.
// Throughput: one item per cycle; the result register lets the next item in while
// the current result waits, and a stalled output holds the input register.
// Reset (arst_n low, asynchronous): north go, dwell count zero, dwell registers at
// their defaults, both pipeline stages empty.
module traffic_light_with_walk_fsm
	import tlw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [1:0] car_sensors, [2] walk_request, [7:3] zero
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // [5:0] vehicle_lights, [7:6] walk_lights,
	                                    // [11:8] state_number, [15:12] zero
	input  logic             cfg_we,
	input  reg_idx_t         cfg_idx,
	input  logic [REG_W-1:0] cfg_data
);

	logic             valid_s1;
	logic [2:0]       sel_s1;
	logic             m_valid_q;
	lamps_t           lamps_q;
	state_t           state_q;
	logic [REG_W-1:0] dwell_q;

	cfg_regs_t        regs;
	lamps_t           lamps;
	state_t           state_nxt;
	logic [REG_W-1:0] dwell_nxt;
	logic             take;

	tlw_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.regs     (regs)
	);

	tlw_step u_step (
		.state     (state_q),
		.dwell     (dwell_q),
		.sel       (sel_s1),
		.regs      (regs),
		.lamps     (lamps),
		.state_nxt (state_nxt),
		.dwell_nxt (dwell_nxt)
	);

	assign take     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			state_q   <= ST_NORTH_GO;
			dwell_q   <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
			if (take) begin
				m_valid_q <= 1'b1;
				state_q   <= state_nxt;
				dwell_q   <= dwell_nxt;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sel_s1 <= s_tdata[2:0];
		end
		if (take) begin
			lamps_q <= lamps;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, lamps_q.state_number, lamps_q.walk_lights,
		lamps_q.vehicle_lights};

endmodule

/* sv/tlw_checker.sv */
module tlw_checker
	import tlw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic [5:0] veh;
	logic [1:0] walk;
	logic [3:0] num;

	assign veh  = m_tdata[5:0];
	assign walk = m_tdata[7:6];
	assign num  = m_tdata[11:8];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_car_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !num[3] |-> walk == WALK_DONT && veh != 6'h09)
		else $error("car phase shows wrong lamps");

	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && num == 4'd8 |-> walk == WALK_ON && veh == 6'h09)
		else $error("walk state shows wrong lamps");

	a_flash: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && num[3] && num != 4'd8 |-> veh == 6'h09 && walk == {1'b0, num[0]})
		else $error("flash phase shows wrong lamps");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:12] == 4'd0)
		else $error("result padding not zero");

endmodule

bind traffic_light_with_walk_fsm tlw_checker u_tlw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
